[hw/rtl/c8ic_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c8ic_pkg
// shared constants, codes, state and command types of the instruction core
// ----------------------------------------------------------------------------
package c8ic_pkg;

  localparam int ADDR_W      = 12;
  localparam int MEM_BYTES   = 4096;
  localparam int DISP_W      = 64;
  localparam int DISP_H      = 32;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 6;
  localparam int NUM_V       = 16;
  localparam int V_IDX_W     = 4;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int FONT_BYTES  = 80;

  localparam logic [ADDR_W-1:0] RESET_PC = 12'h200;

  // command codes
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_EXEC  = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_ROW   = 3'd4;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_UNKNOWN   = 3'd1;
  localparam logic [2:0] STS_UNDERFLOW = 3'd2;
  localparam logic [2:0] STS_OVERFLOW  = 3'd3;
  localparam logic [2:0] STS_KEYPAD    = 3'd4;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_DISP, ST_RD_WAIT, ST_F1, ST_F2, ST_F3, ST_F4, ST_EXE,
    ST_FLAG, ST_DRAW_RD, ST_DRAW_WR, ST_BCD0, ST_BCD1, ST_BCD2, ST_DUMP_RD,
    ST_DUMP_WR, ST_LOAD_RD, ST_LOAD_WR, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_ACCEPT, OP_DISPATCH, OP_RD_CAP, OP_F1, OP_F2, OP_F3,
    OP_F4, OP_EXE, OP_FLAG, OP_DRAW_RD, OP_DRAW_WR, OP_BCD0, OP_BCD1, OP_BCD2,
    OP_DUMP_RD, OP_DUMP_WR, OP_LOAD_RD, OP_LOAD_WR, OP_FIN
  } dp_op_t;

  typedef enum logic [2:0] {
    EK_SIMPLE, EK_FLAG, EK_DRAW, EK_BCD, EK_DUMP, EK_LOAD
  } exec_kind_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    exec_kind_t kind;
    logic       init_last;
    logic       draw_last;
    logic       reg_last;
    logic       out_busy;
  } dp_status_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage
`default_nettype wire

[hw/rtl/c8ic_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c8ic_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/c8ic_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c8ic_ctrl
// sequencer: steps commands and instructions through the datapath
// ----------------------------------------------------------------------------
module c8ic_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire c8ic_pkg::dp_status_t dp_sts,
  output c8ic_pkg::ctrl_t           ctrl
);
  import c8ic_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:    if (dp_sts.init_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = ST_DISP;
      ST_DISP: begin
        if (dp_sts.cmd == CMD_READ) state_nxt = ST_RD_WAIT;
        else if (dp_sts.cmd == CMD_EXEC) state_nxt = ST_F1;
        else state_nxt = ST_FIN;
      end
      ST_RD_WAIT: state_nxt = ST_FIN;
      ST_F1:      state_nxt = ST_F2;
      ST_F2:      state_nxt = ST_F3;
      ST_F3:      state_nxt = ST_F4;
      ST_F4:      state_nxt = ST_EXE;
      ST_EXE: begin
        case (dp_sts.kind)
          EK_FLAG: state_nxt = ST_FLAG;
          EK_DRAW: state_nxt = ST_DRAW_RD;
          EK_BCD:  state_nxt = ST_BCD0;
          EK_DUMP: state_nxt = ST_DUMP_RD;
          EK_LOAD: state_nxt = ST_LOAD_RD;
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_FLAG:    state_nxt = ST_FIN;
      ST_DRAW_RD: state_nxt = ST_DRAW_WR;
      ST_DRAW_WR: state_nxt = dp_sts.draw_last ? ST_FLAG : ST_DRAW_RD;
      ST_BCD0:    state_nxt = ST_BCD1;
      ST_BCD1:    state_nxt = ST_BCD2;
      ST_BCD2:    state_nxt = ST_FIN;
      ST_DUMP_RD: state_nxt = ST_DUMP_WR;
      ST_DUMP_WR: state_nxt = dp_sts.reg_last ? ST_FIN : ST_DUMP_RD;
      ST_LOAD_RD: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR: state_nxt = dp_sts.reg_last ? ST_FIN : ST_LOAD_RD;
      ST_FIN:     if (!dp_sts.out_busy) state_nxt = ST_IDLE;
      default:    state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    ctrl.op  = OP_NONE;
    case (state_r)
      ST_INIT:    ctrl.op = OP_INIT;
      ST_IDLE:    if (in_valid) ctrl.op = OP_ACCEPT;
      ST_DISP:    ctrl.op = OP_DISPATCH;
      ST_RD_WAIT: ctrl.op = OP_RD_CAP;
      ST_F1:      ctrl.op = OP_F1;
      ST_F2:      ctrl.op = OP_F2;
      ST_F3:      ctrl.op = OP_F3;
      ST_F4:      ctrl.op = OP_F4;
      ST_EXE:     ctrl.op = OP_EXE;
      ST_FLAG:    ctrl.op = OP_FLAG;
      ST_DRAW_RD: ctrl.op = OP_DRAW_RD;
      ST_DRAW_WR: ctrl.op = OP_DRAW_WR;
      ST_BCD0:    ctrl.op = OP_BCD0;
      ST_BCD1:    ctrl.op = OP_BCD1;
      ST_BCD2:    ctrl.op = OP_BCD2;
      ST_DUMP_RD: ctrl.op = OP_DUMP_RD;
      ST_DUMP_WR: ctrl.op = OP_DUMP_WR;
      ST_LOAD_RD: ctrl.op = OP_LOAD_RD;
      ST_LOAD_WR: ctrl.op = OP_LOAD_WR;
      ST_FIN:     if (!dp_sts.out_busy) ctrl.op = OP_FIN;
      default:    ctrl.op = OP_NONE;
    endcase
  end

`ifndef SYNTH
  a_exe_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXE) |-> ($past(state_r) == ST_F4))
    else $error("execute entered without operand fetch");
  a_draw_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW_WR) |-> ($past(state_r) == ST_DRAW_RD))
    else $error("sprite row written without a read");
`endif

endmodule
`default_nettype wire

[hw/rtl/c8ic_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c8ic_datapath
// architectural state, memories, frame, alu and output word register
// ----------------------------------------------------------------------------
module c8ic_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire c8ic_pkg::ctrl_t                   ctrl,
  output c8ic_pkg::dp_status_t                   dp_sts,
  input  wire logic [2:0]                        in_command,
  input  wire logic [c8ic_pkg::ADDR_W-1:0]       in_address,
  input  wire logic [7:0]                        in_write_data,
  input  wire logic [7:0]                        in_random_byte,
  input  wire logic [c8ic_pkg::ROW_W-1:0]        in_display_row,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [c8ic_pkg::ADDR_W-1:0]       cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_read_data,
  output logic [c8ic_pkg::DISP_W-1:0]            out_row_pixels,
  output logic [c8ic_pkg::ADDR_W-1:0]            out_program_counter,
  output logic                                   out_sound_on,
  output logic [2:0]                             out_status
);
  import c8ic_pkg::*;

  // latched input word
  logic [2:0]        cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        wdata_r, wdata_nxt;
  logic [7:0]        rnd_r, rnd_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  // architectural state
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [7:0]        dt_r, dt_nxt;
  logic [7:0]        st_r, st_nxt;
  logic [DISP_W-1:0] frame_r [DISP_H];
  logic [DISP_W-1:0] frame_nxt [DISP_H];
  logic [ADDR_W-1:0] stack_r [STACK_DEPTH];
  logic              stk_we;
  logic [NUM_V-1:0]  vvalid_r, vvalid_nxt;
  logic              vqv_r;

  // working registers
  logic [7:0]        op_hi_r, op_hi_nxt;
  logic [7:0]        op_lo_r, op_lo_nxt;
  logic [7:0]        vx_r, vx_nxt;
  logic [7:0]        vy_r, vy_nxt;
  logic              flag_r, flag_nxt;
  logic [ADDR_W-1:0] count_r, count_nxt;
  logic [7:0]        rdata_r, rdata_nxt;
  logic [DISP_W-1:0] pix_r, pix_nxt;
  logic [2:0]        status_r, status_nxt;

  // output word
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        o_rdata_r;
  logic [DISP_W-1:0] o_pix_r;
  logic [ADDR_W-1:0] o_pc_r;
  logic              o_snd_r;
  logic [2:0]        o_sts_r;

  // memory ports
  logic              m_we;
  logic [ADDR_W-1:0] m_waddr, m_raddr;
  logic [7:0]        m_wdata, m_q;
  logic              v_we;
  logic [V_IDX_W-1:0] v_waddr, v_raddr;
  logic [7:0]        v_wdata, v_rq, v_q;

  // decode
  logic [3:0]        dx, dy, dn;
  logic [7:0]        dnn;
  logic [ADDR_W-1:0] dnnn;
  logic [ADDR_W-1:0] pc_p2, i_cnt;
  logic [SP_W-1:0]   sp_dec;
  logic [8:0]        sum9;
  exec_kind_t        kind;

  // sprite
  logic [ROW_W-1:0]    dr_row;
  logic [2*DISP_W-1:0] dr_wide;
  logic [DISP_W-1:0]   dr_mask;

  // bcd
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem8;
  logic [6:0]  bcd_rem;
  logic [15:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [6:0]  bcd_o;

  c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_q)
  );

  c8ic_ram #(.WIDTH(8), .DEPTH(NUM_V)) u_vreg (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rq)
  );

  // never-written registers read as zero
  assign v_q = vqv_r ? v_rq : 8'h00;

  assign dx     = op_hi_r[3:0];
  assign dy     = op_lo_r[7:4];
  assign dn     = op_lo_r[3:0];
  assign dnn    = op_lo_r;
  assign dnnn   = {op_hi_r[3:0], op_lo_r};
  assign pc_p2  = pc_r + ADDR_W'(2);
  assign i_cnt  = i_r + count_r;
  assign sp_dec = sp_r - SP_W'(1);
  assign sum9   = {1'b0, vx_r} + {1'b0, vy_r};

  assign dr_row  = vy_r[ROW_W-1:0] + count_r[ROW_W-1:0];
  assign dr_wide = {m_q, {(DISP_W-8){1'b0}}, m_q, {(DISP_W-8){1'b0}}} >> vx_r[COL_W-1:0];
  assign dr_mask = dr_wide[DISP_W-1:0];

  assign bcd_h    = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
  assign bcd_rem8 = vx_r - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
  assign bcd_rem  = bcd_rem8[6:0];
  assign bcd_prod = 16'(bcd_rem) * 16'd205;
  assign bcd_t    = bcd_prod[14:11];
  assign bcd_o    = bcd_rem - (7'({3'b000, bcd_t}) * 7'd10);

  always_comb begin
    kind = EK_SIMPLE;
    case (op_hi_r[7:4])
      4'h8: begin
        if (dn == 4'h4 || dn == 4'h5 || dn == 4'h6 || dn == 4'h7 || dn == 4'hE) begin
          kind = EK_FLAG;
        end
      end
      4'hD: kind = (dn == 4'h0) ? EK_FLAG : EK_DRAW;
      4'hF: begin
        if (dnn == 8'h33) kind = EK_BCD;
        else if (dnn == 8'h55) kind = EK_DUMP;
        else if (dnn == 8'h65) kind = EK_LOAD;
      end
      default: kind = EK_SIMPLE;
    endcase
  end

  assign dp_sts.cmd       = cmd_r;
  assign dp_sts.kind      = kind;
  assign dp_sts.init_last = (count_r == ADDR_W'(MEM_BYTES - 1));
  assign dp_sts.draw_last = (count_r[3:0] == (dn - 4'd1));
  assign dp_sts.reg_last  = (count_r[3:0] == dx);
  assign dp_sts.out_busy  = out_valid_r & out_stall;

  assign cfg_ready = 1'b1;

  always_comb begin
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    wdata_nxt  = wdata_r;
    rnd_nxt    = rnd_r;
    row_nxt    = row_r;
    pc_nxt     = pc_r;
    i_nxt      = i_r;
    sp_nxt     = sp_r;
    dt_nxt     = dt_r;
    st_nxt     = st_r;
    frame_nxt  = frame_r;
    stk_we     = 1'b0;
    vvalid_nxt = vvalid_r;
    op_hi_nxt  = op_hi_r;
    op_lo_nxt  = op_lo_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    flag_nxt   = flag_r;
    count_nxt  = count_r;
    rdata_nxt  = rdata_r;
    pix_nxt    = pix_r;
    status_nxt = status_r;
    m_we       = 1'b0;
    m_waddr    = i_cnt;
    m_wdata    = v_q;
    m_raddr    = i_cnt;
    v_we       = 1'b0;
    v_waddr    = dx;
    v_wdata    = m_q;
    v_raddr    = count_r[V_IDX_W-1:0];

    case (ctrl.op)
      OP_INIT: begin
        // clearing pass with font load
        m_we      = 1'b1;
        m_waddr   = count_r;
        m_wdata   = (count_r < ADDR_W'(FONT_BYTES)) ? FONT[count_r[6:0]] : 8'h00;
        count_nxt = count_r + ADDR_W'(1);
      end
      OP_ACCEPT: begin
        cmd_nxt    = in_command;
        addr_nxt   = in_address;
        wdata_nxt  = in_write_data;
        rnd_nxt    = in_random_byte;
        row_nxt    = in_display_row;
        rdata_nxt  = 8'h00;
        pix_nxt    = '0;
        status_nxt = STS_OK;
      end
      OP_DISPATCH: begin
        case (cmd_r)
          CMD_WRITE: begin
            m_we    = 1'b1;
            m_waddr = addr_r;
            m_wdata = wdata_r;
          end
          CMD_READ: m_raddr = addr_r;
          CMD_EXEC: m_raddr = pc_r;
          CMD_TICK: begin
            if (dt_r != 8'h00) dt_nxt = dt_r - 8'd1;
            if (st_r != 8'h00) st_nxt = st_r - 8'd1;
          end
          CMD_ROW: pix_nxt = frame_r[row_r];
          default: ;
        endcase
      end
      OP_RD_CAP: rdata_nxt = m_q;
      OP_F1: begin
        op_hi_nxt = m_q;
        m_raddr   = pc_r + ADDR_W'(1);
      end
      OP_F2: begin
        op_lo_nxt = m_q;
        v_raddr   = dx;
        pc_nxt    = pc_p2;
      end
      OP_F3: begin
        vx_nxt  = v_q;
        v_raddr = dy;
      end
      OP_F4: vy_nxt = v_q;
      OP_EXE: begin
        count_nxt = '0;
        case (op_hi_r[7:4])
          4'h0: begin
            if (dnnn == 12'h0E0) begin
              for (int r = 0; r < DISP_H; r++) frame_nxt[r] = '0;
            end else if (dnnn == 12'h0EE) begin
              if (sp_r == '0) begin
                status_nxt = STS_UNDERFLOW;
              end else begin
                sp_nxt = sp_dec;
                pc_nxt = stack_r[sp_dec[STK_IDX_W-1:0]];
              end
            end else begin
              status_nxt = STS_UNKNOWN;
            end
          end
          4'h1: pc_nxt = dnnn;
          4'h2: begin
            if (sp_r >= SP_W'(STACK_DEPTH)) begin
              status_nxt = STS_OVERFLOW;
            end else begin
              stk_we = 1'b1;
              sp_nxt = sp_r + SP_W'(1);
              pc_nxt = dnnn;
            end
          end
          4'h3: if (vx_r == dnn) pc_nxt = pc_p2;
          4'h4: if (vx_r != dnn) pc_nxt = pc_p2;
          4'h5: begin
            if (dn != 4'h0) status_nxt = STS_UNKNOWN;
            else if (vx_r == vy_r) pc_nxt = pc_p2;
          end
          4'h6: begin
            v_we    = 1'b1;
            v_wdata = dnn;
          end
          4'h7: begin
            v_we    = 1'b1;
            v_wdata = vx_r + dnn;
          end
          4'h8: begin
            v_we = 1'b1;
            case (dn)
              4'h0: v_wdata = vy_r;
              4'h1: v_wdata = vx_r | vy_r;
              4'h2: v_wdata = vx_r & vy_r;
              4'h3: v_wdata = vx_r ^ vy_r;
              4'h4: begin
                v_wdata  = sum9[7:0];
                flag_nxt = sum9[8];
              end
              4'h5: begin
                v_wdata  = vx_r - vy_r;
                flag_nxt = (vx_r >= vy_r);
              end
              4'h6: begin
                v_wdata  = {1'b0, vx_r[7:1]};
                flag_nxt = vx_r[0];
              end
              4'h7: begin
                v_wdata  = vy_r - vx_r;
                flag_nxt = (vy_r >= vx_r);
              end
              4'hE: begin
                v_wdata  = {vx_r[6:0], 1'b0};
                flag_nxt = vx_r[7];
              end
              default: begin
                v_we       = 1'b0;
                status_nxt = STS_UNKNOWN;
              end
            endcase
          end
          4'h9: begin
            if (dn != 4'h0) status_nxt = STS_UNKNOWN;
            else if (vx_r != vy_r) pc_nxt = pc_p2;
          end
          4'hA: i_nxt = dnnn;
          4'hB: pc_nxt = dnnn + ADDR_W'(vx_r);
          4'hC: begin
            v_we    = 1'b1;
            v_wdata = rnd_r & dnn;
          end
          4'hD: flag_nxt = 1'b0;
          4'hE: begin
            if (dnn == 8'h9E || dnn == 8'hA1) status_nxt = STS_KEYPAD;
            else status_nxt = STS_UNKNOWN;
          end
          default: begin
            case (dnn)
              8'h07: begin
                v_we    = 1'b1;
                v_wdata = dt_r;
              end
              8'h0A: status_nxt = STS_KEYPAD;
              8'h15: dt_nxt = vx_r;
              8'h18: st_nxt = vx_r;
              8'h1E: i_nxt = i_r + ADDR_W'(vx_r);
              8'h29: i_nxt = ADDR_W'(11'(vx_r) * 11'd5);
              8'h33, 8'h55, 8'h65: ;
              default: status_nxt = STS_UNKNOWN;
            endcase
          end
        endcase
      end
      OP_FLAG: begin
        v_we    = 1'b1;
        v_waddr = V_IDX_W'(NUM_V - 1);
        v_wdata = {7'b0, flag_r};
      end
      OP_DRAW_RD: m_raddr = i_cnt;
      OP_DRAW_WR: begin
        flag_nxt          = flag_r | (|(frame_r[dr_row] & dr_mask));
        frame_nxt[dr_row] = frame_r[dr_row] ^ dr_mask;
        count_nxt         = count_r + ADDR_W'(1);
      end
      OP_BCD0: begin
        m_we    = 1'b1;
        m_waddr = i_r;
        m_wdata = {6'b0, bcd_h};
      end
      OP_BCD1: begin
        m_we    = 1'b1;
        m_waddr = i_r + ADDR_W'(1);
        m_wdata = {4'b0, bcd_t};
      end
      OP_BCD2: begin
        m_we    = 1'b1;
        m_waddr = i_r + ADDR_W'(2);
        m_wdata = {1'b0, bcd_o};
      end
      OP_DUMP_RD: v_raddr = count_r[V_IDX_W-1:0];
      OP_DUMP_WR: begin
        m_we      = 1'b1;
        m_waddr   = i_cnt;
        m_wdata   = v_q;
        count_nxt = count_r + ADDR_W'(1);
      end
      OP_LOAD_RD: m_raddr = i_cnt;
      OP_LOAD_WR: begin
        v_we      = 1'b1;
        v_waddr   = count_r[V_IDX_W-1:0];
        v_wdata   = m_q;
        count_nxt = count_r + ADDR_W'(1);
      end
      default: ;
    endcase

    if (v_we) vvalid_nxt[v_waddr] = 1'b1;

    // start address write reloads the program counter
    if (cfg_valid && cfg_ready) pc_nxt = cfg_data;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.op == OP_FIN) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= RESET_PC;
      i_r         <= '0;
      sp_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      vvalid_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < DISP_H; r++) frame_r[r] <= '0;
    end else begin
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sp_r        <= sp_nxt;
      dt_r        <= dt_nxt;
      st_r        <= st_nxt;
      vvalid_r    <= vvalid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      frame_r     <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    rnd_r    <= rnd_nxt;
    row_r    <= row_nxt;
    op_hi_r  <= op_hi_nxt;
    op_lo_r  <= op_lo_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    flag_r   <= flag_nxt;
    rdata_r  <= rdata_nxt;
    pix_r    <= pix_nxt;
    status_r <= status_nxt;
    vqv_r    <= vvalid_r[v_raddr];
    if (stk_we) stack_r[sp_r[STK_IDX_W-1:0]] <= pc_r;
    if (ctrl.op == OP_FIN) begin
      o_rdata_r <= rdata_r;
      o_pix_r   <= pix_r;
      o_pc_r    <= pc_r;
      o_snd_r   <= (st_r != 8'h00);
      o_sts_r   <= status_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = o_rdata_r;
  assign out_row_pixels      = o_pix_r;
  assign out_program_counter = o_pc_r;
  assign out_sound_on        = o_snd_r;
  assign out_status          = o_sts_r;

`ifndef SYNTH
  a_sp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");
  a_fin_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_FIN) |=> out_valid_r)
    else $error("finished word not presented");
`endif

endmodule
`default_nettype wire

[hw/rtl/chip8_instruction_core_top.sv]
`default_nettype none
// throughput: one command word at a time; the next word is taken in the cycle after
//   the result is loaded into the output register, which waits while out_stall holds
// reset: synchronous rst_n; a pass over all 4096 bytes then clears memory and loads the
//   font, with in_stall high; configuration writes are taken throughout
// ----------------------------------------------------------------------------
// chip8_instruction_core_top
// interpreter core: sequencer plus datapath with 4 KiB memory and 64x32 frame
// ----------------------------------------------------------------------------
module chip8_instruction_core_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // command word channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_command,
  input  wire logic [c8ic_pkg::ADDR_W-1:0] in_address,
  input  wire logic [7:0]                  in_write_data,
  input  wire logic [7:0]                  in_random_byte,
  input  wire logic [c8ic_pkg::ROW_W-1:0]  in_display_row,
  // start address register
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [c8ic_pkg::ADDR_W-1:0] cfg_data,
  // result word channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_read_data,
  output logic [c8ic_pkg::DISP_W-1:0]      out_row_pixels,
  output logic [c8ic_pkg::ADDR_W-1:0]      out_program_counter,
  output logic                             out_sound_on,
  output logic [2:0]                       out_status
);
  import c8ic_pkg::*;

  // command from sequencer, status back from datapath
  ctrl_t      ctrl;
  dp_status_t dp_sts;

  // sequencer: one state per memory access or register file access
  c8ic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_sts   (dp_sts),
    .ctrl     (ctrl)
  );

  // datapath: memory, registers, stack, timers, frame and output word
  c8ic_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .dp_sts              (dp_sts),
    .in_command          (in_command),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .in_random_byte      (in_random_byte),
    .in_display_row      (in_display_row),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_row_pixels      (out_row_pixels),
    .out_program_counter (out_program_counter),
    .out_sound_on        (out_sound_on),
    .out_status          (out_status)
  );

endmodule
`default_nettype wire

[dv/tb_chip8_instruction_core_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_core_top
// drives command words into the instruction core and checks every result
// word against a cycle-free mirror of the interpreter state
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core_top;
  import c8ic_pkg::*;

  typedef struct {
    logic [7:0]  rd;
    logic [63:0] px;
    logic [11:0] pc;
    logic        snd;
    logic [2:0]  sts;
  } result_word_t;

  // mirror of the core state, predicts one result word per command word
  class core_mirror;
    logic [11:0]  start_pc;
    logic [7:0]   mem [MEM_BYTES];
    logic [7:0]   v [NUM_V];
    logic [11:0]  idx;
    logic [11:0]  pc;
    logic [11:0]  stk [STACK_DEPTH];
    int           sp;
    logic [7:0]   dtimer;
    logic [7:0]   stimer;
    logic [63:0]  frame [DISP_H];
    result_word_t expected_words [$];
    int           mismatches;

    function new();
      start_pc = RESET_PC;
      foreach (mem[i]) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
      foreach (v[i]) v[i] = 8'h00;
      foreach (frame[i]) frame[i] = '0;
      idx = '0; pc = start_pc; sp = 0; dtimer = '0; stimer = '0;
      mismatches = 0;
    endfunction

    function void load_start(logic [11:0] a);
      start_pc = a;
      pc = a;
    endfunction

    function void sprite(int x, int y, int rows);
      int x0, y0, yy, xx;
      logic [7:0] bits;
      logic hit;
      logic [63:0] m;
      x0 = v[x]; y0 = v[y]; hit = 0;
      for (int r = 0; r < rows; r++) begin
        bits = mem[(idx + r) & 12'hFFF];
        yy = (y0 + r) % DISP_H;
        for (int c = 0; c < 8; c++) begin
          if (bits[7-c]) begin
            xx = (x0 + c) % DISP_W;
            m = 64'd1 << (63 - xx);
            if (frame[yy] & m) hit = 1;
            frame[yy] ^= m;
          end
        end
      end
      v[15] = {7'd0, hit};
    endfunction

    function logic [2:0] execute(logic [7:0] rnd);
      logic [15:0] op;
      logic [11:0] nnn;
      logic [7:0] nn, a, b, res;
      logic flg;
      logic [3:0] n;
      int x, y;
      op  = {mem[pc], mem[(pc + 1) & 12'hFFF]};
      nnn = op[11:0]; nn = op[7:0]; n = op[3:0];
      x = op[11:8]; y = op[7:4];
      pc = pc + 12'd2;
      case (op[15:12])
        4'h0: begin
          if (op == 16'h00E0) begin
            foreach (frame[i]) frame[i] = '0;
          end else if (op == 16'h00EE) begin
            if (sp == 0) return STS_UNDERFLOW;
            sp--;
            pc = stk[sp];
          end else return STS_UNKNOWN;
        end
        4'h1: pc = nnn;
        4'h2: begin
          if (sp >= STACK_DEPTH) return STS_OVERFLOW;
          stk[sp] = pc;
          sp++;
          pc = nnn;
        end
        4'h3: if (v[x] == nn) pc = pc + 12'd2;
        4'h4: if (v[x] != nn) pc = pc + 12'd2;
        4'h5: begin
          if (n != 0) return STS_UNKNOWN;
          if (v[x] == v[y]) pc = pc + 12'd2;
        end
        4'h6: v[x] = nn;
        4'h7: v[x] = v[x] + nn;
        4'h8: begin
          a = v[x]; b = v[y];
          case (n)
            4'h0: begin v[x] = b; return STS_OK; end
            4'h1: begin v[x] = a | b; return STS_OK; end
            4'h2: begin v[x] = a & b; return STS_OK; end
            4'h3: begin v[x] = a ^ b; return STS_OK; end
            4'h4: begin res = a + b; flg = ({1'b0, a} + {1'b0, b} > 9'hFF); end
            4'h5: begin res = a - b; flg = (a >= b); end
            4'h7: begin res = b - a; flg = (b >= a); end
            4'h6: begin res = a >> 1; flg = a[0]; end
            4'hE: begin res = a << 1; flg = a[7]; end
            default: return STS_UNKNOWN;
          endcase
          // result first, flag last so vf keeps the flag
          v[x] = res;
          v[15] = {7'd0, flg};
        end
        4'h9: begin
          if (n != 0) return STS_UNKNOWN;
          if (v[x] != v[y]) pc = pc + 12'd2;
        end
        4'hA: idx = nnn;
        4'hB: pc = nnn + v[x];
        4'hC: v[x] = rnd & nn;
        4'hD: sprite(x, y, n);
        4'hE: begin
          if (nn == 8'h9E || nn == 8'hA1) return STS_KEYPAD;
          return STS_UNKNOWN;
        end
        default: begin
          case (nn)
            8'h07: v[x] = dtimer;
            8'h0A: return STS_KEYPAD;
            8'h15: dtimer = v[x];
            8'h18: stimer = v[x];
            8'h1E: idx = idx + v[x];
            8'h29: idx = 12'(5 * v[x]);
            8'h33: begin
              mem[idx] = 8'(v[x] / 100);
              mem[(idx + 1) & 12'hFFF] = 8'((v[x] / 10) % 10);
              mem[(idx + 2) & 12'hFFF] = 8'(v[x] % 10);
            end
            8'h55: for (int i = 0; i <= x; i++) mem[(idx + i) & 12'hFFF] = v[i];
            8'h65: for (int i = 0; i <= x; i++) v[i] = mem[(idx + i) & 12'hFFF];
            default: return STS_UNKNOWN;
          endcase
        end
      endcase
      return STS_OK;
    endfunction

    function void note_command(logic [2:0] cmd, logic [11:0] addr, logic [7:0] wd,
                               logic [7:0] rnd, logic [4:0] row);
      result_word_t w;
      w.rd = '0; w.px = '0; w.sts = STS_OK;
      case (cmd)
        CMD_WRITE: mem[addr] = wd;
        CMD_READ:  w.rd = mem[addr];
        CMD_EXEC:  w.sts = execute(rnd);
        CMD_TICK: begin
          if (dtimer != 0) dtimer--;
          if (stimer != 0) stimer--;
        end
        CMD_ROW:   w.px = frame[row];
        default: ;
      endcase
      w.pc = pc;
      w.snd = (stimer != 0);
      expected_words.insert(expected_words.size(), w);
    endfunction

    function void check_result(result_word_t got);
      result_word_t e;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word pc=%h", got.pc);
        return;
      end
      e = expected_words.pop_front();
      if (got.rd !== e.rd || got.px !== e.px || got.pc !== e.pc ||
          got.snd !== e.snd || got.sts !== e.sts) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp rd=%h px=%h pc=%h snd=%b sts=%0d",
                    " / got rd=%h px=%h pc=%h snd=%b sts=%0d"},
                   e.rd, e.px, e.pc, e.snd, e.sts,
                   got.rd, got.px, got.pc, got.snd, got.sts);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  localparam int NUM_RANDOM = 1500;
  localparam int QUIET_TAIL = 150;
  localparam int WATCHDOG   = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [11:0] in_address;
  logic [7:0]  in_write_data;
  logic [7:0]  in_random_byte;
  logic [4:0]  in_display_row;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic [63:0] out_row_pixels;
  logic [11:0] out_program_counter;
  logic        out_sound_on;
  logic [2:0]  out_status;

  core_mirror mirror;
  bit         quiet;     // no idling in the last part of the run
  int         sent;
  int         idle_cycles;

  chip8_instruction_core_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .in_random_byte      (in_random_byte),
    .in_display_row      (in_display_row),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_row_pixels      (out_row_pixels),
    .out_program_counter (out_program_counter),
    .out_sound_on        (out_sound_on),
    .out_status          (out_status)
  );

  // 8 ns clock
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** chip8_instruction_core_top: FAILED **");
      $finish;
    end
  end

  // result side: check accepted words, stall in random bursts
  initial begin : result_side
    result_word_t got;
    int burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.rd = out_read_data; got.px = out_row_pixels; got.pc = out_program_counter;
        got.snd = out_sound_on; got.sts = out_status;
        mirror.check_result(got);
      end
      if (burst > 0) begin
        burst--;
        out_stall <= (burst > 0);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one command word; valid stays high into the next word unless a gap follows
  task automatic send_word(logic [2:0] cmd, logic [11:0] addr, logic [7:0] wd,
                           logic [7:0] rnd, logic [4:0] row);
    int gap;
    if (!in_valid) in_valid <= 1'b1;
    in_command <= cmd; in_address <= addr; in_write_data <= wd;
    in_random_byte <= rnd; in_display_row <= row;
    do @(posedge clk); while (in_stall);
    mirror.note_command(cmd, addr, wd, rnd, row);
    sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // place an opcode at the current program counter and execute it
  task automatic run_opcode(logic [15:0] op, logic [7:0] rnd);
    logic [11:0] at;
    at = mirror.pc;
    send_word(CMD_WRITE, at, op[15:8], 8'($urandom), 5'($urandom));
    send_word(CMD_WRITE, at + 12'd1, op[7:0], 8'($urandom), 5'($urandom));
    send_word(CMD_EXEC, 12'($urandom), 8'($urandom), rnd, 5'($urandom));
  endtask

  // register writes only with the core idle
  task automatic write_start(logic [11:0] a);
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.load_start(a);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [3:0] x, y, k;
    logic [7:0] nn;
    x = 4'($urandom); y = 4'($urandom); nn = 8'($urandom);
    k = 4'($urandom);
    case (k)
      4'h0: case ($urandom_range(0, 2))
              0: return 16'h00E0;
              1: return 16'h00EE;
              default: return {4'h0, 12'($urandom)};
            endcase
      4'h5, 4'h9: return {k, x, y, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0};
      4'h8: return {k, x, y, 4'($urandom)};
      4'hD: return {k, x, y,
                    ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4))};
      4'hE: case ($urandom_range(0, 2))
              0: return {k, x, 8'h9E};
              1: return {k, x, 8'hA1};
              default: return {k, x, nn};
            endcase
      4'hF: case ($urandom_range(0, 9))
              0: return {k, x, 8'h07};
              1: return {k, x, 8'h0A};
              2: return {k, x, 8'h15};
              3: return {k, x, 8'h18};
              4: return {k, x, 8'h1E};
              5: return {k, x, 8'h29};
              6: return {k, x, 8'h33};
              7: return {k, x, 8'h55};
              8: return {k, x, 8'h65};
              default: return {k, x, nn};
            endcase
      default: return {k, x, nn};
    endcase
  endfunction

  // random phase: mostly well-formed opcode runs, some raw noise
  task automatic random_phase(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      if (sent > NUM_RANDOM - QUIET_TAIL + 60) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0, 1: send_word(3'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                        5'($urandom));
        2:    send_word(CMD_TICK, 12'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
        3:    send_word(CMD_ROW, 12'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
        4:    send_word(CMD_READ, 12'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
        5: begin
          // deep call chain to reach overflow
          if ($urandom_range(0, 3) == 0)
            repeat (18) run_opcode({4'h2, 12'($urandom)}, 8'($urandom));
          else
            run_opcode(16'h00EE, 8'($urandom));
        end
        default: run_opcode(random_opcode(), 8'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    mirror = new();
    quiet = 1'b0;
    sent = 0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= '0; in_address <= '0; in_write_data <= '0;
    in_random_byte <= '0; in_display_row <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, underflow, flag on vf, font draw
    send_word(CMD_WRITE, 12'hFFF, 8'hFF, 8'h00, 5'd0);
    send_word(CMD_READ, 12'hFFF, 8'h00, 8'hFF, 5'd31);
    send_word(CMD_READ, 12'h000, 8'h00, 8'h00, 5'd0);
    run_opcode(16'h00EE, 8'h00);
    run_opcode(16'h6FFF, 8'h00);
    run_opcode(16'h8FF5, 8'h00);
    run_opcode(16'hD005, 8'h00);
    send_word(CMD_ROW, 12'h000, 8'h00, 8'h00, 5'd0);
    send_word(CMD_ROW, 12'h000, 8'h00, 8'h00, 5'd31);
    send_word(3'd7, 12'hFFF, 8'hFF, 8'hFF, 5'd31);
    send_word(CMD_TICK, 12'h000, 8'h00, 8'h00, 5'd0);

    write_start(12'hFFF);
    random_phase(300);
    write_start(12'h000);
    random_phase(300);
    write_start(12'($urandom));
    random_phase(300);
    write_start(RESET_PC);
    random_phase(NUM_RANDOM - 900);

    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0)
      $display("** chip8_instruction_core_top: PASSED **");
    else
      $display("** chip8_instruction_core_top: FAILED **");
    $finish;
  end

endmodule
